// File: hdl/ihex_pkg.sv
`timescale 1ns / 1ps

package ihex_pkg;

  // Record parsing phases
  typedef enum logic [3:0] {
    PH_START = 4'd0,
    PH_COUNT = 4'd1,
    PH_ADDR  = 4'd2,
    PH_TYPE  = 4'd3,
    PH_DATA  = 4'd4,
    PH_SUM   = 4'd5,
    PH_EOL   = 4'd6
  } phase_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_UPPER = 8'h41;
  localparam logic [7:0] CHAR_LOWER = 8'h61;
  localparam logic [7:0] HEX_TEN    = 8'd10;
  localparam logic [7:0] REC_EOF    = 8'h01;

  // One result beat
  typedef struct packed {
    kind_e       kind;
    logic [16:0] offset;
    logic [7:0]  value;
  } out_beat_t;

  // Hex digit decode; anything that is not a hex digit reads as zero
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = 8'd0;
      if (c inside {[8'h30:8'h39]}) begin
        v = c - CHAR_ZERO;
      end else if (c inside {[8'h41:8'h46]}) begin
        v = c - CHAR_UPPER + HEX_TEN;
      end else if (c inside {[8'h61:8'h66]}) begin
        v = c - CHAR_LOWER + HEX_TEN;
      end
      return v[3:0];
    end
  endfunction

endpackage

// File: hdl/ihex_out_buf.sv
`timescale 1ns / 1ps

// Two-entry output stage: a main register plus a skid register so the
// upstream stall comes from a flop only.
module ihex_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ihex_pkg::out_beat_t   push_beat_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ihex_pkg::out_beat_t   out_beat_o
);

  logic                main_valid_q, main_valid_d;
  logic                skid_valid_q, skid_valid_d;
  ihex_pkg::out_beat_t main_q, main_d;
  ihex_pkg::out_beat_t skid_q, skid_d;
  logic                pop;

  assign pop = main_valid_q && !out_stall_i;

  // Next-state for both entries
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = push_i;
        main_d       = push_beat_i;
      end
    end else if (!main_valid_q) begin
      main_valid_d = push_i;
      main_d       = push_beat_i;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_beat_o  = main_q;

`ifndef SYNTHESIS
  a_skid_implies_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry held without main entry");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("push into full output stage");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (main_valid_q && !skid_valid_q))
    else $error("skid entry not moved to main register");
`endif

endmodule

// File: hdl/intel_hex_record_parser.sv
`timescale 1ns / 1ps

// Channel  | valid        | stall        | payload
// ---------+--------------+--------------+----------------------------------
// input    | in_valid_i   | in_stall_o   | ascii_char_i
// output   | out_valid_o  | out_stall_i  | kind_o, byte_offset_o, byte_value_o
// config   | start_address_we_i (no stall) | start_address_i
//
// One character per cycle while in_stall_o is low; each beat is decoded and
// the record fields are updated in the cycle it is accepted; any result is
// registered in the output stage. in_stall_o rises only when both output entries
// are full. Reset clears all parser state and start_address to zero. After a done
// or start-code error result the parser drops all characters until reset.
module intel_hex_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_address_we_i,
  input  logic [15:0] start_address_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ascii_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [16:0] byte_offset_o,
  output logic [7:0]  byte_value_o
);

  logic [15:0]      start_q;
  ihex_pkg::phase_e phase_q, phase_d;
  logic [2:0]       digit_q, digit_d;
  logic [7:0]       len_q, len_d;
  logic [15:0]      addr_q, addr_d;
  logic [7:0]       rtype_q, rtype_d;
  logic [3:0]       high_q, high_d;
  logic [7:0]       idx_q, idx_d;
  logic             halted_q, halted_d;

  logic                accept;
  logic                buf_full;
  logic [3:0]          nib;
  logic [7:0]          idx_next;
  logic [16:0]         offset;
  logic                res_valid;
  ihex_pkg::out_beat_t res_beat;
  ihex_pkg::out_beat_t out_beat;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;
  assign nib        = ihex_pkg::nibble_of(ascii_char_i);
  assign idx_next   = idx_q + 8'd1;
  assign offset     = {1'b0, addr_q} - {1'b0, start_q} + {9'd0, idx_q};

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 16'd0;
    end else if (start_address_we_i) begin
      start_q <= start_address_i;
    end
  end

  // Character decode and record field update
  always_comb begin
    phase_d   = phase_q;
    digit_d   = digit_q;
    len_d     = len_q;
    addr_d    = addr_q;
    rtype_d   = rtype_q;
    high_d    = high_q;
    idx_d     = idx_q;
    halted_d  = halted_q;
    res_valid = 1'b0;
    res_beat  = '{kind: ihex_pkg::KIND_DATA, offset: 17'd0, value: 8'd0};
    if (accept && !halted_q) begin
      case (phase_q)
        ihex_pkg::PH_COUNT: begin
          len_d = {len_q[3:0], nib};
          if (digit_q == 3'd1) begin
            digit_d = 3'd0;
            addr_d  = 16'd0;
            phase_d = ihex_pkg::PH_ADDR;
          end else begin
            digit_d = digit_q + 3'd1;
          end
        end
        ihex_pkg::PH_ADDR: begin
          addr_d = {addr_q[11:0], nib};
          if (digit_q == 3'd3) begin
            digit_d = 3'd0;
            rtype_d = 8'd0;
            phase_d = ihex_pkg::PH_TYPE;
          end else begin
            digit_d = digit_q + 3'd1;
          end
        end
        ihex_pkg::PH_TYPE: begin
          rtype_d = {rtype_q[3:0], nib};
          if (digit_q == 3'd1) begin
            digit_d = 3'd0;
            idx_d   = 8'd0;
            phase_d = (len_q == 8'd0) ? ihex_pkg::PH_SUM : ihex_pkg::PH_DATA;
          end else begin
            digit_d = digit_q + 3'd1;
          end
        end
        ihex_pkg::PH_DATA: begin
          if (digit_q == 3'd0) begin
            high_d  = nib;
            digit_d = 3'd1;
          end else begin
            digit_d = 3'd0;
            idx_d   = idx_next;
            if (idx_next == len_q || idx_next == 8'd0) begin
              phase_d = ihex_pkg::PH_SUM;
            end
            // keep only records at or above the start address
            if (addr_q >= start_q) begin
              res_valid = 1'b1;
              res_beat  = '{kind: ihex_pkg::KIND_DATA, offset: offset,
                            value: {high_q, nib}};
            end
          end
        end
        ihex_pkg::PH_SUM: begin
          if (digit_q == 3'd1) begin
            digit_d = 3'd0;
            phase_d = ihex_pkg::PH_EOL;
            // end-of-file record: empty or type 1
            if (len_q == 8'd0 || rtype_q == ihex_pkg::REC_EOF) begin
              halted_d  = 1'b1;
              phase_d   = ihex_pkg::PH_START;
              res_valid = 1'b1;
              res_beat  = '{kind: ihex_pkg::KIND_DONE, offset: 17'd0, value: 8'd0};
            end
          end else begin
            digit_d = digit_q + 3'd1;
          end
        end
        ihex_pkg::PH_EOL: begin
          if (digit_q == 3'd1) begin
            digit_d = 3'd0;
            phase_d = ihex_pkg::PH_START;
          end else begin
            digit_d = digit_q + 3'd1;
          end
        end
        default: begin
          if (ascii_char_i != ihex_pkg::CHAR_COLON) begin
            halted_d  = 1'b1;
            res_valid = 1'b1;
            res_beat  = '{kind: ihex_pkg::KIND_ERROR, offset: 17'd0, value: 8'd0};
          end else begin
            digit_d = 3'd0;
            len_d   = 8'd0;
            phase_d = ihex_pkg::PH_COUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ihex_pkg::PH_START;
      digit_q  <= 3'd0;
      len_q    <= 8'd0;
      addr_q   <= 16'd0;
      rtype_q  <= 8'd0;
      high_q   <= 4'd0;
      idx_q    <= 8'd0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      digit_q  <= digit_d;
      len_q    <= len_d;
      addr_q   <= addr_d;
      rtype_q  <= rtype_d;
      high_q   <= high_d;
      idx_q    <= idx_d;
      halted_q <= halted_d;
    end
  end

  // Result register with skid entry
  ihex_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_beat_i (res_beat),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat)
  );

  assign kind_o        = out_beat.kind;
  assign byte_offset_o = out_beat.offset;
  assign byte_value_o  = out_beat.value;

`ifndef SYNTHESIS
  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt released without reset");

  a_no_result_when_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !res_valid)
    else $error("result produced while halted");

  a_halt_has_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!halted_q && halted_d) |-> (res_valid && res_beat.kind != ihex_pkg::KIND_DATA))
    else $error("halt entered without status result");
`endif

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int          NUM_SETTINGS    = 8;
  localparam int          CHARS_PER_PHASE = 100;
  localparam int          CYCLE_LIMIT     = 500000;
  localparam logic [7:0]  CHAR_CR         = 8'h0D;
  localparam logic [7:0]  CHAR_LF         = 8'h0A;

  // How the stream is closed; the parser halts after any of these
  typedef enum int {
    END_EMPTY_RECORD,
    END_EOF_RECORD,
    END_BAD_START
  } ending_e;

  // One row of the directed character table
  typedef struct packed {
    logic [7:0]          ch;
    bit                  typed;
    ihex_pkg::out_beat_t beat;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_address_we_i;
  logic [15:0] start_address_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  ascii_char_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [16:0] byte_offset_o;
  logic [7:0]  byte_value_o;

  intel_hex_record_parser DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_address_we_i (start_address_we_i),
    .start_address_i    (start_address_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .ascii_char_i       (ascii_char_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .kind_o             (kind_o),
    .byte_offset_o      (byte_offset_o),
    .byte_value_o       (byte_value_o)
  );

  // Parser state mirrored by the predictor
  ihex_pkg::phase_e rec_phase     = ihex_pkg::PH_START;
  logic [2:0]       rec_digits    = '0;
  logic [7:0]       rec_len       = '0;
  logic [15:0]      rec_addr      = '0;
  logic [7:0]       rec_type      = '0;
  logic [3:0]       rec_hi        = '0;
  logic [7:0]       rec_idx       = '0;
  bit               parser_halted = 1'b0;
  logic [15:0]      start_addr    = '0;

  ihex_pkg::out_beat_t pending_beats[$];
  ihex_pkg::out_beat_t want;
  stim_row_t           dir_rows[$];
  int                  mismatch_count = 0;
  int                  cycle_count    = 0;
  int                  chars_sent     = 0;
  int                  stall_left     = 0;
  bit                  idle_on        = 1'b0;
  bit                  noise_on       = 1'b0;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Hex digit value; anything else counts as zero
  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= ihex_pkg::CHAR_ZERO && c < ihex_pkg::CHAR_ZERO + 8'd10) begin
      v = c - ihex_pkg::CHAR_ZERO;
    end else if (c >= ihex_pkg::CHAR_UPPER && c < ihex_pkg::CHAR_UPPER + 8'd6) begin
      v = c - ihex_pkg::CHAR_UPPER + ihex_pkg::HEX_TEN;
    end else if (c >= ihex_pkg::CHAR_LOWER && c < ihex_pkg::CHAR_LOWER + 8'd6) begin
      v = c - ihex_pkg::CHAR_LOWER + ihex_pkg::HEX_TEN;
    end
    return v[3:0];
  endfunction

  // Character for a nibble: mixed case, and with noise on a zero may be any non-hex byte
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n == 4'd0 && noise_on && $urandom_range(0, 3) == 0) begin
      c = 8'($urandom_range(0, 255));
      while (digit_value(c) != 4'd0 || c == ihex_pkg::CHAR_ZERO) begin
        c = 8'($urandom_range(0, 255));
      end
    end else if (n < 4'd10) begin
      c = ihex_pkg::CHAR_ZERO + {4'd0, n};
    end else if ($urandom_range(0, 1) == 1) begin
      c = ihex_pkg::CHAR_UPPER + {4'd0, n} - ihex_pkg::HEX_TEN;
    end else begin
      c = ihex_pkg::CHAR_LOWER + {4'd0, n} - ihex_pkg::HEX_TEN;
    end
    return c;
  endfunction

  function automatic stim_row_t row(input logic [7:0] ch, input bit typed,
                                    input ihex_pkg::kind_e k,
                                    input logic [16:0] off, input logic [7:0] val);
    stim_row_t r;
    r.ch         = ch;
    r.typed      = typed;
    r.beat.kind  = k;
    r.beat.offset = off;
    r.beat.value = val;
    return r;
  endfunction

  // Advance the record parser by one character; fired marks a result beat
  task automatic predict_char(input logic [7:0] c, output bit fired,
                              output ihex_pkg::out_beat_t beat);
    logic [3:0] nib;
    logic [7:0] nidx;
    nib   = digit_value(c);
    fired = 1'b0;
    beat  = '0;
    if (!parser_halted) begin
      case (rec_phase)
        ihex_pkg::PH_COUNT: begin
          rec_len    = {rec_len[3:0], nib};
          rec_digits = rec_digits + 3'd1;
          if (rec_digits == 3'd2) begin
            rec_digits = '0;
            rec_addr   = '0;
            rec_phase  = ihex_pkg::PH_ADDR;
          end
        end
        ihex_pkg::PH_ADDR: begin
          rec_addr   = {rec_addr[11:0], nib};
          rec_digits = rec_digits + 3'd1;
          if (rec_digits == 3'd4) begin
            rec_digits = '0;
            rec_type   = '0;
            rec_phase  = ihex_pkg::PH_TYPE;
          end
        end
        ihex_pkg::PH_TYPE: begin
          rec_type   = {rec_type[3:0], nib};
          rec_digits = rec_digits + 3'd1;
          if (rec_digits == 3'd2) begin
            rec_digits = '0;
            rec_idx    = '0;
            rec_phase  = (rec_len == 8'd0) ? ihex_pkg::PH_SUM : ihex_pkg::PH_DATA;
          end
        end
        ihex_pkg::PH_DATA: begin
          if (rec_digits == 3'd0) begin
            rec_hi     = nib;
            rec_digits = 3'd1;
          end else begin
            rec_digits = '0;
            nidx       = rec_idx + 8'd1;
            if (nidx == rec_len || nidx == 8'd0) begin
              rec_phase = ihex_pkg::PH_SUM;
            end
            // records below the start address are parsed but dropped
            if (rec_addr >= start_addr) begin
              fired       = 1'b1;
              beat.kind   = ihex_pkg::KIND_DATA;
              beat.offset = {1'b0, rec_addr} - {1'b0, start_addr} + {9'd0, rec_idx};
              beat.value  = {rec_hi, nib};
            end
            rec_idx = nidx;
          end
        end
        ihex_pkg::PH_SUM: begin
          rec_digits = rec_digits + 3'd1;
          if (rec_digits == 3'd2) begin
            rec_digits = '0;
            rec_phase  = ihex_pkg::PH_EOL;
            // empty record or end-of-file type closes the stream
            if (rec_len == 8'd0 || rec_type == ihex_pkg::REC_EOF) begin
              parser_halted = 1'b1;
              rec_phase     = ihex_pkg::PH_START;
              fired         = 1'b1;
              beat.kind     = ihex_pkg::KIND_DONE;
            end
          end
        end
        ihex_pkg::PH_EOL: begin
          rec_digits = rec_digits + 3'd1;
          if (rec_digits == 3'd2) begin
            rec_digits = '0;
            rec_phase  = ihex_pkg::PH_START;
          end
        end
        default: begin
          if (c != ihex_pkg::CHAR_COLON) begin
            parser_halted = 1'b1;
            fired         = 1'b1;
            beat.kind     = ihex_pkg::KIND_ERROR;
          end else begin
            rec_digits = '0;
            rec_len    = '0;
            rec_phase  = ihex_pkg::PH_COUNT;
          end
        end
      endcase
    end
  endtask

  task automatic flag_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Drive one character beat; called and returns at a falling edge
  task automatic send_char(input logic [7:0] c, input bit typed,
                           input ihex_pkg::out_beat_t typed_beat);
    bit                  fired;
    ihex_pkg::out_beat_t b;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    ascii_char_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_char(c, fired, b);
    if (typed) begin
      pending_beats.push_back(typed_beat);
    end else if (fired) begin
      pending_beats.push_back(b);
    end
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_plain(input logic [7:0] c);
    send_char(c, 1'b0, '0);
  endtask

  task automatic send_byte(input logic [7:0] v);
    send_plain(hex_char(v[7:4]));
    send_plain(hex_char(v[3:0]));
  endtask

  // Full record: random data, unchecked checksum, line end usually CR LF
  task automatic send_record(input logic [7:0] count, input logic [15:0] addr,
                             input logic [7:0] rtype);
    send_plain(ihex_pkg::CHAR_COLON);
    send_byte(count);
    send_byte(addr[15:8]);
    send_byte(addr[7:0]);
    send_byte(rtype);
    for (int i = 0; i < count; i++) begin
      send_byte(8'($urandom_range(0, 255)));
    end
    send_plain(8'($urandom_range(0, 255)));
    send_plain(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) begin
      send_plain(8'($urandom_range(0, 255)));
      send_plain(8'($urandom_range(0, 255)));
    end else begin
      send_plain(CHAR_CR);
      send_plain(CHAR_LF);
    end
  endtask

  // Register write once the parser has drained; called at a falling edge
  task automatic write_start(input logic [15:0] v);
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    start_address_we_i <= 1'b1;
    start_address_i    <= v;
    @(negedge clk_i);
    start_address_we_i <= 1'b0;
    start_addr = v;
  endtask

  // Result side: random stall bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each result beat with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_beats.size() == 0) begin
        flag_mismatch($sformatf("beat with nothing expected: kind %0d offset %h value %h",
                                kind_o, byte_offset_o, byte_value_o));
      end else begin
        want = pending_beats.pop_front();
        if (kind_o != want.kind) begin
          flag_mismatch($sformatf("kind %0d, expected %0d", kind_o, want.kind));
        end
        if (byte_offset_o != want.offset) begin
          flag_mismatch($sformatf("offset %h, expected %h", byte_offset_o, want.offset));
        end
        if (byte_value_o != want.value) begin
          flag_mismatch($sformatf("value %h, expected %h", byte_value_o, want.value));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [7:0]  count;
    logic [7:0]  rtype;
    logic [7:0]  c;
    logic [15:0] addr;
    logic [15:0] next_start;
    int          sel;
    int          budget;
    ending_e     ending;

    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    ascii_char_i       = 8'd0;
    out_stall_i        = 1'b0;
    start_address_we_i = 1'b0;
    start_address_i    = 16'd0;

    // Directed record at the top address: 0xFF lands at 0xFFFF, a non-hex
    // digit reads as zero, the second byte crosses into offset bit 16
    dir_rows.push_back(row(ihex_pkg::CHAR_COLON, 1'b0, ihex_pkg::KIND_DATA, '0, '0));
    dir_rows.push_back(row("0", 1'b0, ihex_pkg::KIND_DATA, '0, '0));
    dir_rows.push_back(row("2", 1'b0, ihex_pkg::KIND_DATA, '0, '0));
    dir_rows.push_back(row("F", 1'b0, ihex_pkg::KIND_DATA, '0, '0));
    dir_rows.push_back(row("F", 1'b0, ihex_pkg::KIND_DATA, '0, '0));
    dir_rows.push_back(row("f", 1'b0, ihex_pkg::KIND_DATA, '0, '0));
    dir_rows.push_back(row("F", 1'b0, ihex_pkg::KIND_DATA, '0, '0));
    dir_rows.push_back(row("0", 1'b0, ihex_pkg::KIND_DATA, '0, '0));
    dir_rows.push_back(row("0", 1'b0, ihex_pkg::KIND_DATA, '0, '0));
    dir_rows.push_back(row("F", 1'b0, ihex_pkg::KIND_DATA, '0, '0));
    dir_rows.push_back(row("f", 1'b1, ihex_pkg::KIND_DATA, 17'h0FFFF, 8'hFF));
    dir_rows.push_back(row("0", 1'b0, ihex_pkg::KIND_DATA, '0, '0));
    dir_rows.push_back(row("g", 1'b1, ihex_pkg::KIND_DATA, 17'h10000, 8'h00));
    dir_rows.push_back(row(8'hFF, 1'b0, ihex_pkg::KIND_DATA, '0, '0));
    dir_rows.push_back(row(8'h80, 1'b0, ihex_pkg::KIND_DATA, '0, '0));
    dir_rows.push_back(row(8'h00, 1'b0, ihex_pkg::KIND_DATA, '0, '0));
    dir_rows.push_back(row(CHAR_LF, 1'b0, ihex_pkg::KIND_DATA, '0, '0));

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_on = 1'b1;
    foreach (dir_rows[i]) begin
      send_char(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].beat);
    end

    // Random records under several start addresses
    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      case (ph)
        0:       next_start = 16'hFFFF;
        1:       next_start = 16'h0000;
        default: next_start = 16'($urandom_range(0, 65535));
      endcase
      write_start(next_start);
      idle_on  = (ph != 2) && (ph != NUM_SETTINGS - 1);
      noise_on = $urandom_range(0, 1);
      budget   = chars_sent + CHARS_PER_PHASE;
      while (chars_sent < budget) begin
        count = ($urandom_range(0, 39) == 0) ? 8'($urandom_range(200, 255))
                                             : 8'($urandom_range(1, 16));
        sel   = $urandom_range(0, 9);
        if (sel < 4) begin
          addr = start_addr + 16'($urandom_range(0, 15));
        end else if (sel < 6) begin
          addr = start_addr - 16'($urandom_range(1, 15));
        end else if (sel == 6) begin
          addr = 16'hFFFF;
        end else begin
          addr = 16'($urandom_range(0, 65535));
        end
        rtype = ($urandom_range(0, 1) == 1) ? 8'h00 : 8'($urandom_range(0, 255));
        if (rtype == ihex_pkg::REC_EOF) begin
          rtype = 8'h00;
        end
        send_record(count, addr, rtype);
      end
    end

    // Close the stream one way or another, then show that it stays halted
    ending = ending_e'($urandom_range(0, 2));
    case (ending)
      END_EMPTY_RECORD: send_record(8'h00, 16'($urandom_range(0, 65535)),
                                    8'($urandom_range(0, 255)));
      END_EOF_RECORD:   send_record(8'($urandom_range(1, 8)), start_addr,
                                    ihex_pkg::REC_EOF);
      default: begin
        c = 8'($urandom_range(0, 255));
        while (c == ihex_pkg::CHAR_COLON) c = 8'($urandom_range(0, 255));
        send_plain(c);
      end
    endcase
    for (int i = 0; i < 12; i++) begin
      send_plain(($urandom_range(0, 2) == 0) ? ihex_pkg::CHAR_COLON
                                             : 8'($urandom_range(0, 255)));
    end
    in_valid_i <= 1'b0;

    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: intel_hex_record_parser.f
hdl/ihex_pkg.sv
hdl/ihex_out_buf.sv
hdl/intel_hex_record_parser.sv
test/tb.sv
